### sv/kmne_pkg.sv
// Package with the shared types and constants of the key matrix note event block.
`timescale 1ns / 1ps
`default_nettype none

package kmne_pkg;

  localparam int unsigned ROW_FIELD_W = 6;
  localparam int unsigned COL_W       = 4;
  localparam int unsigned TRACK_W     = 12;
  localparam int unsigned KEY_ROW_W   = 3;
  localparam int unsigned VOICE_W     = 2;
  localparam int unsigned SWITCH_W    = 3;

  typedef enum logic {
    OP_SCAN  = 1'b0,
    OP_VOICE = 1'b1
  } op_e;

  typedef enum logic [VOICE_W-1:0] {
    VOICE_NONE = 2'd0,
    VOICE_A    = 2'd1,
    VOICE_B    = 2'd2,
    VOICE_C    = 2'd3
  } voice_e;

  typedef logic [TRACK_W-1:0] track_t;

  typedef struct packed {
    logic [ROW_FIELD_W-1:0]              press;
    logic [ROW_FIELD_W-1:0]              release_mask;
    logic [ROW_FIELD_W-1:0][TRACK_W-1:0] track;
    logic [COL_W-1:0]                    column;
  } burst_t;

endpackage

`default_nettype wire

### sv/kmne_lane.sv
// One row lane: detects a press or release and builds the event track number.
`timescale 1ns / 1ps
`default_nettype none

module kmne_lane
  import kmne_pkg::*;
#(
  parameter int unsigned ROW = 0
) (
  input  wire logic               new_bit_i,
  input  wire logic               old_bit_i,
  input  wire logic [VOICE_W-1:0] voice_i,
  input  wire logic [COL_W-1:0]   column_i,
  output logic                    press_o,
  output logic                    release_o,
  output track_t                  track_o
);

  logic [5:0] base;

  assign press_o   = new_bit_i & ~old_bit_i;
  assign release_o = ~new_bit_i & old_bit_i;

  // Voice and row each give one digit; the column gives one or two.
  assign base = 6'(voice_i) * 6'd10 + 6'(ROW);

  always_comb begin
    if (column_i >= COL_W'(10)) begin
      track_o = TRACK_W'(base) * TRACK_W'(100) + TRACK_W'(column_i);
    end else begin
      track_o = TRACK_W'(base) * TRACK_W'(10) + TRACK_W'(column_i);
    end
  end

endmodule

`default_nettype wire

### sv/kmne_merge.sv
// Merge stage: walks lane results into the output register, one event a cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module kmne_merge
  import kmne_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_valid_i,
  input  wire burst_t           load_i,
  output logic                  load_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  is_release_o,
  output track_t                track_o,
  output logic [KEY_ROW_W-1:0]  key_row_o,
  output logic [COL_W-1:0]      key_column_o,
  output logic                  last_o
);

  logic                                busy_q;
  logic [ROW_FIELD_W-1:0]              press_q;
  logic [ROW_FIELD_W-1:0]              rel_q;
  logic [ROW_FIELD_W-1:0][TRACK_W-1:0] track_q;
  logic [COL_W-1:0]                    col_q;

  logic [ROW_FIELD_W-1:0] pick_mask;
  logic [ROW_FIELD_W-1:0] clr;
  logic [ROW_FIELD_W-1:0] press_nx;
  logic [ROW_FIELD_W-1:0] rel_nx;
  logic [KEY_ROW_W-1:0]   sel;
  logic                   sel_rel;
  logic                   emit;
  logic                   finishing;
  logic                   load;

  always_comb begin
    sel_rel   = (press_q == '0);
    pick_mask = sel_rel ? rel_q : press_q;
    sel       = '0;
    for (int i = ROW_FIELD_W - 1; i >= 0; i--) begin
      if (pick_mask[i]) begin
        sel = KEY_ROW_W'(i);
      end
    end
    clr      = ROW_FIELD_W'(1) << sel;
    press_nx = sel_rel ? press_q : (press_q & ~clr);
    rel_nx   = sel_rel ? (rel_q & ~clr) : rel_q;
  end

  assign emit         = busy_q && (!out_valid_o || out_ready_i);
  assign finishing    = emit && (press_nx == '0) && (rel_nx == '0);
  assign load_ready_o = !busy_q || finishing;
  assign load         = load_valid_i && load_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      press_q     <= '0;
      rel_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_o  <= 1'b1;
        is_release_o <= sel_rel;
        track_o      <= track_q[sel];
        key_row_o    <= sel;
        key_column_o <= col_q;
        last_o       <= finishing;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (load) begin
        busy_q  <= 1'b1;
        press_q <= load_i.press;
        rel_q   <= load_i.release_mask;
        track_q <= load_i.track;
        col_q   <= load_i.column;
      end else if (emit) begin
        press_q <= press_nx;
        rel_q   <= rel_nx;
        if (finishing) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  a_busy_has_events : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((press_q | rel_q) != '0))
    else $error("Merge stage is busy with no pending event.");

  a_idle_is_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ((press_q == '0) && (rel_q == '0)))
    else $error("Merge stage holds events while idle.");

  a_load_has_events : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ((load_i.press | load_i.release_mask) != '0))
    else $error("Empty request loaded into the merge stage.");

endmodule

`default_nettype wire

### sv/key_matrix_note_events.sv
// Top level of the key matrix note event generator.
`timescale 1ns / 1ps
`default_nettype none

// A scan request that causes events is registered in the input stage once accepted, then loaded
// into the merging stage, and from there reaches the output register; either step can stall.
// A column request emits its events one a cycle while the output is not stalled, presses first and
// then releases, each in ascending row order. A request causes at most six events; the merging
// stage has a single output port and takes the next request as its last event is emitted.
// Voice switch requests, unchanged columns and out-of-range columns emit nothing and do not wait
// for the merging stage. The pressed map sits in a memory of COLUMNS entries with one valid
// bit per entry, cleared at once by reset, so no clearing pass is needed after reset.
module key_matrix_note_events
  import kmne_pkg::*;
#(
  parameter int unsigned ROWS    = 6,
  parameter int unsigned COLUMNS = 11
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   operation_i,
  input  wire logic [COL_W-1:0]       column_i,
  input  wire logic [ROW_FIELD_W-1:0] row_bits_i,
  input  wire logic [SWITCH_W-1:0]    switch_bits_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        is_release_o,
  output logic [TRACK_W-1:0]          track_o,
  output logic [KEY_ROW_W-1:0]        key_row_o,
  output logic [COL_W-1:0]            key_column_o,
  output logic                        last_o
);

  localparam int unsigned AR  = (ROWS < ROW_FIELD_W) ? ROWS : ROW_FIELD_W;
  localparam int unsigned CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [AR-1:0]  map_mem [COLUMNS];
  logic [COLUMNS-1:0] map_vld_q;
  logic [AR-1:0]  rdata_q;

  logic                   s1_valid_q;
  op_e                    s1_op_q;
  logic [COL_W-1:0]       s1_col_q;
  logic [ROW_FIELD_W-1:0] s1_bits_q;
  logic [SWITCH_W-1:0]    s1_sw_q;
  logic                   fwd_q;
  logic [AR-1:0]          fwd_data_q;
  logic [VOICE_W-1:0]     voice_q;

  logic                   in_acc;
  logic                   in_in_range;
  logic [CIW-1:0]         in_idx;
  logic                   s1_in_range;
  logic [CIW-1:0]         s1_idx;
  logic                   s1_scan;
  logic [AR-1:0]          old_map;
  logic [AR-1:0]          new_map;
  logic                   has_evt;
  logic                   s1_adv;
  logic                   s1_wr;
  logic                   merge_ready;
  burst_t                 burst;

  assign in_in_range = (32'(column_i) < COLUMNS);
  assign in_idx      = CIW'(column_i);
  assign s1_in_range = (32'(s1_col_q) < COLUMNS);
  assign s1_idx      = CIW'(s1_col_q);
  assign s1_scan     = s1_valid_q && (s1_op_q == OP_SCAN) && s1_in_range;
  assign new_map     = s1_bits_q[AR-1:0];

  always_comb begin
    if (fwd_q) begin
      old_map = fwd_data_q;
    end else if (s1_in_range && map_vld_q[s1_idx]) begin
      old_map = rdata_q;
    end else begin
      old_map = '0;
    end
  end

  assign has_evt    = s1_scan && (new_map != old_map);
  assign s1_adv     = s1_valid_q && (!has_evt || merge_ready);
  assign s1_wr      = s1_adv && s1_scan;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  for (genvar r = 0; r < ROW_FIELD_W; r++) begin : g_lane
    if (r < AR) begin : g_on
      kmne_lane #(
        .ROW(r)
      ) u_lane (
        .new_bit_i (new_map[r]),
        .old_bit_i (old_map[r]),
        .voice_i   (voice_q),
        .column_i  (s1_col_q),
        .press_o   (burst.press[r]),
        .release_o (burst.release_mask[r]),
        .track_o   (burst.track[r])
      );
    end else begin : g_off
      assign burst.press[r]        = 1'b0;
      assign burst.release_mask[r] = 1'b0;
      assign burst.track[r]        = '0;
    end
  end
  assign burst.column = s1_col_q;

  kmne_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid_q && has_evt),
    .load_i       (burst),
    .load_ready_o (merge_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_release_o (is_release_o),
    .track_o      (track_o),
    .key_row_o    (key_row_o),
    .key_column_o (key_column_o),
    .last_o       (last_o)
  );

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      map_mem[s1_idx] <= new_map;
    end
    if (in_acc && in_in_range) begin
      rdata_q <= map_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      map_vld_q  <= '0;
      voice_q    <= VOICE_NONE;
      fwd_q      <= 1'b0;
    end else begin
      if (s1_wr) begin
        map_vld_q[s1_idx] <= 1'b1;
      end
      if (s1_adv && (s1_op_q == OP_VOICE)) begin
        if (s1_sw_q[2]) begin
          voice_q <= VOICE_C;
        end else if (s1_sw_q[1]) begin
          voice_q <= VOICE_B;
        end else if (s1_sw_q[0]) begin
          voice_q <= VOICE_A;
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_op_q    <= op_e'(operation_i);
        s1_col_q   <= column_i;
        s1_bits_q  <= row_bits_i;
        s1_sw_q    <= switch_bits_i;
        fwd_q      <= s1_wr && (s1_col_q == column_i);
        fwd_data_q <= new_map;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  a_voice_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (voice_q != VOICE_NONE) |=> (voice_q != VOICE_NONE))
    else $error("Voice number returned to zero after being set.");

  a_event_column : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(key_column_o) < COLUMNS))
    else $error("Event reported for a column outside the matrix.");

  a_evt_is_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_evt |-> (s1_valid_q && (s1_op_q == OP_SCAN)))
    else $error("Events raised by a request that is not a column scan.");

endmodule

`default_nettype wire
